FILE: src/plc_pkg.sv
// Shared types and constants for the piecewise-linear curve block.
`default_nettype none
package plc_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = 5;
   localparam int DATA_W     = 32;
   localparam int ENTRY_W    = 2 * DATA_W;
   localparam int DIV_STEPS  = DATA_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int REQ_DATA_W = 104;

   typedef enum logic {
      ACT_LOAD  = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_RD_Y,
      RES_LERP
   } res_sel_type;

   typedef struct packed {
      logic              q_load;
      logic [IDX_W-1:0]  rd_addr;
      logic              a_load;
      logic              seg_load;
      logic              mul;
      logic              div_start;
      logic              div_step;
      res_sel_type       res_sel;
      logic              res_load;
      logic              out_load;
   } plc_cmd_type;

   typedef struct packed {
      logic q_le_rd_x;
      logic q_ge_rd_x;
      logic q_ge_a_x;
   } plc_stat_type;

endpackage
`default_nettype wire

FILE: src/plc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module plc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: src/plc_dpath.sv
// Datapath: query and segment registers, multiplier, serial divider, result registers.
`default_nettype none
module plc_dpath (
   input  wire logic                        clock,
   input  wire plc_pkg::plc_cmd_type        cmd,
   input  wire logic [plc_pkg::DATA_W-1:0]  req_query_x,
   input  wire logic [plc_pkg::ENTRY_W-1:0] rd_data,
   output      plc_pkg::plc_stat_type       stat,
   output      logic [plc_pkg::DATA_W-1:0]  rsp_curve_y,
   output      logic                        rsp_found
);
   import plc_pkg::*;

   logic signed [DATA_W-1:0] q_ff, q_in;
   logic signed [DATA_W-1:0] a_x_ff, a_x_in;
   logic signed [DATA_W-1:0] a_y_ff, a_y_in;
   logic [DATA_W-1:0]        off_ff, off_in;
   logic [DATA_W-1:0]        dx_ff, dx_in;
   logic [DATA_W-1:0]        mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [2*DATA_W-1:0]      prod_ff, prod_in;
   logic [DATA_W-1:0]        rem_ff, rem_in;
   logic [DATA_W-1:0]        quo_ff, quo_in;
   logic [DATA_W-1:0]        res_y_ff, res_y_in;
   logic                     res_found_ff, res_found_in;
   logic [DATA_W-1:0]        out_y_ff, out_y_in;
   logic                     out_found_ff, out_found_in;

   logic signed [DATA_W-1:0] rd_x;
   logic signed [DATA_W-1:0] rd_y;
   logic signed [DATA_W:0]   dy;
   logic [DATA_W:0]          trial;
   logic [DATA_W:0]          diff;
   logic                     fits;

   assign rd_x = $signed(rd_data[DATA_W-1:0]);
   assign rd_y = $signed(rd_data[ENTRY_W-1:DATA_W]);
   assign dy   = {rd_y[DATA_W-1], rd_y} - {a_y_ff[DATA_W-1], a_y_ff};

   assign trial = {rem_ff, quo_ff[DATA_W-1]};
   assign diff  = trial - {1'b0, dx_ff};
   assign fits  = (trial >= {1'b0, dx_ff});

   assign stat.q_le_rd_x = (q_ff <= rd_x);
   assign stat.q_ge_rd_x = (q_ff >= rd_x);
   assign stat.q_ge_a_x  = (q_ff >= a_x_ff);

   always_comb begin
      q_in         = cmd.q_load ? $signed(req_query_x) : q_ff;
      a_x_in       = cmd.a_load ? rd_x : a_x_ff;
      a_y_in       = cmd.a_load ? rd_y : a_y_ff;
      off_in       = off_ff;
      dx_in        = dx_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      res_y_in     = res_y_ff;
      res_found_in = res_found_ff;
      out_y_in     = out_y_ff;
      out_found_in = out_found_ff;

      if (cmd.seg_load) begin
         off_in = DATA_W'(q_ff - a_x_ff);
         dx_in  = DATA_W'(rd_x - a_x_ff);
         neg_in = dy[DATA_W];
         mag_in = dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];
      end
      if (cmd.mul) begin
         prod_in = off_ff * mag_ff;
      end
      if (cmd.div_start) begin
         rem_in = prod_ff[2*DATA_W-1:DATA_W];
         quo_in = prod_ff[DATA_W-1:0];
      end else if (cmd.div_step) begin
         rem_in = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], fits};
      end
      if (cmd.res_load) begin
         case (cmd.res_sel)
            RES_RD_Y: begin
               res_y_in     = rd_y;
               res_found_in = 1'b1;
            end
            RES_LERP: begin
               res_y_in     = neg_ff ? DATA_W'(a_y_ff - quo_ff) : DATA_W'(a_y_ff + quo_ff);
               res_found_in = 1'b1;
            end
            default: begin
               res_y_in     = '0;
               res_found_in = 1'b0;
            end
         endcase
      end
      if (cmd.out_load) begin
         out_y_in     = res_y_ff;
         out_found_in = res_found_ff;
      end
   end

   always_ff @(posedge clock) begin
      q_ff         <= q_in;
      a_x_ff       <= a_x_in;
      a_y_ff       <= a_y_in;
      off_ff       <= off_in;
      dx_ff        <= dx_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      res_y_ff     <= res_y_in;
      res_found_ff <= res_found_in;
      out_y_ff     <= out_y_in;
      out_found_ff <= out_found_in;
   end

   assign rsp_curve_y = out_y_ff;
   assign rsp_found   = out_found_ff;

endmodule
`default_nettype wire

FILE: src/plc_ctrl.sv
// Controller: point count register, query sequencer and output handshake.
`default_nettype none
module plc_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [plc_pkg::CNT_W-1:0]  csr_wr_data,
   input  wire logic                       req_tvalid,
   input  wire logic                       req_action,
   output      logic                       req_tready,
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   input  wire plc_pkg::plc_stat_type      stat,
   output      plc_pkg::plc_cmd_type       cmd
);
   import plc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIRST,
      S_LAST,
      S_SCAN,
      S_MUL,
      S_DLOAD,
      S_DIV,
      S_ADD,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]   n_clamp;
   logic [IDX_W-1:0]   last_idx;
   logic               query_acc;

   assign n_clamp   = (count_ff > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_ff;
   assign last_idx  = IDX_W'(n_ff - CNT_W'(1));
   assign req_tready = (state_ff == S_IDLE);
   assign query_acc = req_tvalid && req_tready && (req_action == ACT_QUERY);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.res_sel  = RES_NONE;

      unique case (state_ff)
         S_IDLE: begin
            if (query_acc) begin
               cmd.q_load = 1'b1;
               n_in       = n_clamp;
               if (n_clamp == '0) begin
                  cmd.res_load = 1'b1;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            cmd.a_load = 1'b1;
            if (n_ff == CNT_W'(1) || stat.q_le_rd_x) begin
               cmd.res_sel  = RES_RD_Y;
               cmd.res_load = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.rd_addr = last_idx;
               state_in    = S_LAST;
            end
         end
         S_LAST: begin
            if (stat.q_ge_rd_x) begin
               cmd.res_sel  = RES_RD_Y;
               cmd.res_load = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.rd_addr = IDX_W'(1);
               idx_in      = IDX_W'(1);
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.q_ge_a_x && !stat.q_ge_rd_x) begin
               cmd.seg_load = 1'b1;
               state_in     = S_MUL;
            end else if (idx_ff == last_idx) begin
               cmd.res_load = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.a_load  = 1'b1;
               cmd.rd_addr = idx_ff + IDX_W'(1);
               idx_in      = idx_ff + IDX_W'(1);
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DLOAD;
         end
         S_DLOAD: begin
            cmd.div_start = 1'b1;
            step_in       = '0;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.res_sel  = RES_LERP;
            cmd.res_load = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         n_ff         <= '0;
         idx_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         n_ff         <= n_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (idx_ff != '0 && idx_ff <= last_idx))
      else $error("scan index outside table");

   a_n_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (n_ff <= CNT_W'(MAX_POINTS) && n_ff != '0 || state_ff == S_DONE))
      else $error("point count not clamped");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      query_acc |=> !req_tready)
      else $error("query did not occupy the sequencer");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside done state");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD) |-> $past(state_ff == S_DIV) && $past(step_ff == STEP_W'(DIV_STEPS - 1)))
      else $error("divider ended early");

endmodule
`default_nettype wire

FILE: src/piecewise_linear_curve.sv
// Top level: piecewise-linear curve evaluator over a loadable breakpoint table.
//
//  port group   direction  payload (low bit up)
//  req_*        in         tuser: action; tdata: point_index, point_x, point_y, query_x
//  rsp_*        out        tuser: found; tdata: curve_y
//  csr_*        in         wr_data: point_count
//
//  A load writes the table as it is accepted; an empty table answers not found. A query
//  takes the first point when it clamps low or the table has one point, the last point
//  when it clamps high, and otherwise scans the segments in turn (at most 15), answering
//  not found if none holds it, else multiply, divider load, 32 divider steps, final add.
//  reset is synchronous; it clears point_count, not the table.
//  A finished result waits in the output register while the next item is taken.
`default_nettype none
module piecewise_linear_curve (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [plc_pkg::CNT_W-1:0]      csr_wr_data,
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   // [3:0] point_index, [35:4] point_x, [67:36] point_y, [99:68] query_x
   input  wire logic [plc_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] action
   input  wire logic [0:0]                     req_tuser,
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [31:0] curve_y
   output      logic [plc_pkg::DATA_W-1:0]     rsp_tdata,
   // [0] found
   output      logic [0:0]                     rsp_tuser
);
   import plc_pkg::*;

   plc_cmd_type         cmd;
   plc_stat_type        stat;
   logic [ENTRY_W-1:0]  rd_data;
   logic                load_wr;
   logic [IDX_W-1:0]    point_index;
   logic [DATA_W-1:0]   point_x;
   logic [DATA_W-1:0]   point_y;
   logic [DATA_W-1:0]   query_x;

   assign point_index = req_tdata[IDX_W-1:0];
   assign point_x     = req_tdata[4 +: DATA_W];
   assign point_y     = req_tdata[4 + DATA_W +: DATA_W];
   assign query_x     = req_tdata[4 + 2*DATA_W +: DATA_W];
   assign load_wr     = req_tvalid && req_tready && (req_tuser[0] == ACT_LOAD);

   plc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_action  (req_tuser[0]),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .stat        (stat),
      .cmd         (cmd)
   );

   plc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (point_index),
      .wr_data ({point_y, point_x}),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   plc_dpath u_dpath (
      .clock       (clock),
      .cmd         (cmd),
      .req_query_x (query_x),
      .rd_data     (rd_data),
      .stat        (stat),
      .rsp_curve_y (rsp_tdata),
      .rsp_found   (rsp_tuser[0])
   );

endmodule
`default_nettype wire

FILE: dv/tb_piecewise_linear_curve.sv
// Self-checking testbench for the piecewise-linear curve block: table loads, queries, stalls.
`default_nettype none
module tb_piecewise_linear_curve;
   timeunit 1ns;
   timeprecision 1ps;
   import plc_pkg::*;

   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam int SETTLE_CYCLES = 64;

   typedef struct {
      action_type              act;
      logic [IDX_W-1:0]        idx;
      logic signed [DATA_W-1:0] px;
      logic signed [DATA_W-1:0] py;
      logic signed [DATA_W-1:0] qx;
   } curve_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] curve_y;
      logic              found;
   } curve_result_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [CNT_W-1:0]       csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata   = '0;
   logic [0:0]             req_tuser   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [DATA_W-1:0]      rsp_tdata;
   logic [0:0]             rsp_tuser;

   curve_item_type   pending_items[$];
   curve_result_type expected_curve[$];
   curve_item_type   cur_item;

   logic signed [DATA_W-1:0] model_x [MAX_POINTS];
   logic signed [DATA_W-1:0] model_y [MAX_POINTS];
   logic [CNT_W-1:0]         model_count = '0;
   logic signed [DATA_W-1:0] plan_x  [MAX_POINTS];
   logic signed [DATA_W-1:0] plan_y  [MAX_POINTS];

   int send_idle_pct = 24;
   int recv_idle_pct = 81;
   int err_count     = 0;

   piecewise_linear_curve i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      err_count++;
   endtask

   function automatic curve_result_type eval_curve(logic signed [DATA_W-1:0] q);
      curve_result_type res;
      int              n;
      int              i;
      longint          off;
      longint          dx;
      longint          dy;
      longint unsigned mag;
      longint unsigned part;
      longint          y;
      res.curve_y = '0;
      res.found   = 1'b0;
      n = (model_count > MAX_POINTS) ? MAX_POINTS : int'(model_count);
      if (n == 1) begin
         res.curve_y = model_y[0];
         res.found   = 1'b1;
      end else if (n > 1) begin
         if (q <= model_x[0]) begin
            res.curve_y = model_y[0];
            res.found   = 1'b1;
         end else if (q >= model_x[n-1]) begin
            res.curve_y = model_y[n-1];
            res.found   = 1'b1;
         end else begin
            for (i = 0; i + 1 < n && !res.found; i++) begin
               if (q >= model_x[i] && q < model_x[i+1]) begin
                  off  = longint'(q) - longint'(model_x[i]);
                  dx   = longint'(model_x[i+1]) - longint'(model_x[i]);
                  dy   = longint'(model_y[i+1]) - longint'(model_y[i]);
                  mag  = (dy < 0) ? $unsigned(-dy) : $unsigned(dy);
                  part = ($unsigned(off) * mag) / $unsigned(dx);
                  y    = (dy < 0) ? longint'(model_y[i]) - $signed(part)
                                  : longint'(model_y[i]) + $signed(part);
                  res.curve_y = y[DATA_W-1:0];
                  res.found   = 1'b1;
               end
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (cur_item.act == ACT_LOAD) begin
               model_x[cur_item.idx] = cur_item.px;
               model_y[cur_item.idx] = cur_item.py;
            end else begin
               expected_curve.push_back(eval_curve(cur_item.qx));
            end
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= cur_item.act;
               req_tdata  <= {{(REQ_DATA_W-3*DATA_W-IDX_W){1'b0}},
                              cur_item.qx, cur_item.py, cur_item.px, cur_item.idx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      curve_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_curve.size() == 0) begin
               report_mismatch($sformatf("unexpected result curve_y=%h found=%b",
                                         rsp_tdata, rsp_tuser[0]));
            end else begin
               want = expected_curve.pop_front();
               if (rsp_tdata !== want.curve_y)
                  report_mismatch($sformatf("curve_y got %h want %h",
                                            rsp_tdata, want.curve_y));
               if (rsp_tuser[0] !== want.found)
                  report_mismatch($sformatf("found got %b want %b",
                                            rsp_tuser[0], want.found));
            end
         end
      end
   end

   task automatic push_load(int idx, logic signed [DATA_W-1:0] x,
                            logic signed [DATA_W-1:0] y);
      curve_item_type it;
      it.act = ACT_LOAD;
      it.idx = idx[IDX_W-1:0];
      it.px  = x;
      it.py  = y;
      it.qx  = $urandom;
      plan_x[idx] = x;
      plan_y[idx] = y;
      pending_items.push_back(it);
   endtask

   task automatic push_query(logic signed [DATA_W-1:0] q);
      curve_item_type it;
      it.act = ACT_QUERY;
      it.idx = IDX_W'($urandom_range(MAX_POINTS-1));
      it.px  = $urandom;
      it.py  = $urandom;
      it.qx  = q;
      pending_items.push_back(it);
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_curve.size() != 0);
   endtask

   task automatic change_count(int value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[CNT_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      model_count = value[CNT_W-1:0];
   endtask

   function automatic logic signed [DATA_W-1:0] pick_y();
      case ($urandom_range(7))
         0:       return Q_MIN;
         1:       return Q_MAX;
         default: return $urandom;
      endcase
   endfunction

   task automatic build_table(int m);
      int                       mode;
      int                       k;
      int                       pos;
      bit                       down;
      longint                   base;
      logic signed [DATA_W-1:0] v;
      logic signed [DATA_W-1:0] xs[$];
      mode = $urandom_range(2);
      down = 1'($urandom_range(1));
      xs   = {};
      base = longint'($urandom_range(32'hBFFF_FFFF, 0)) - 64'sd2147483648;
      for (k = 0; k < m; k++) begin
         if (mode == 0) begin
            v   = $urandom;
            pos = 0;
            while (pos < xs.size() && xs[pos] < v) pos++;
            xs.insert(pos, v);
         end else begin
            xs.push_back(base[DATA_W-1:0]);
            base += (mode == 1) ? $urandom_range(32'h0400_0000, 1) : $urandom_range(64, 1);
         end
      end
      for (k = 0; k < m; k++) begin
         pos = down ? m - 1 - k : k;
         push_load(pos, xs[pos], pick_y());
      end
   endtask

   task automatic push_curve_query(int m);
      int                       r;
      int                       i;
      longint unsigned          span;
      longint                   q;
      r = $urandom_range(99);
      if (m >= 2 && r < 55) begin
         i = $urandom_range(m - 2);
         if (plan_x[i+1] > plan_x[i]) begin
            span = $unsigned(longint'(plan_x[i+1]) - longint'(plan_x[i]));
            q = longint'(plan_x[i]) + $signed({$urandom, $urandom} % span);
            push_query(q[DATA_W-1:0]);
         end else begin
            push_query($urandom);
         end
      end else if (m >= 1 && r < 70) begin
         push_query(plan_x[$urandom_range(m - 1)] + $urandom_range(2) - 1);
      end else if (r < 80) begin
         push_query($urandom_range(1) ? Q_MAX : Q_MIN);
      end else begin
         push_query($urandom);
      end
   endtask

   task automatic run_phase(int count, int n_items);
      int  m;
      int  total;
      int  k;
      int  burst;
      bit  held;
      change_count(count);
      m     = (count > MAX_POINTS) ? MAX_POINTS : count;
      total = 0;
      held  = 1'b0;
      if (m >= 1) begin
         build_table(m);
         total += m;
      end
      while (total < n_items) begin
         if ($urandom_range(99) < 80) begin
            if (m >= 1 && $urandom_range(3) == 0) begin
               build_table(m);
               total += m;
            end
            burst = $urandom_range(10, 3);
            for (k = 0; k < burst; k++) push_curve_query(m);
            total += burst;
         end else begin
            burst = $urandom_range(4, 1);
            for (k = 0; k < burst; k++) begin
               if ($urandom_range(1))
                  push_load($urandom_range(MAX_POINTS-1), $urandom, $urandom);
               else
                  push_query($urandom);
            end
            total += burst;
         end
         if (!held && total >= n_items / 2) begin
            wait_drained();
            held = 1'b1;
         end
      end
   endtask

   initial begin : stimulus
      int counts[12];
      int p;
      counts = '{16, 2, 31, 1, 0, 17, 5, 16, 3, 16, 9, 31};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      push_query(Q_MIN);
      push_query(Q_MAX);
      push_load(0, Q_MIN, Q_MAX);
      push_load(1, Q_MAX, Q_MIN);
      change_count(1);
      push_query(32'sd0);
      change_count(2);
      push_query(Q_MIN);
      push_query(Q_MAX);
      push_query(32'sd0);
      push_query(Q_MIN + 1);
      push_query(Q_MAX - 1);
      push_load(1, -32'sh5_0000, 32'sh3_0000);
      push_load(0, 32'sh5_0000, -32'sh2_0000);
      push_query(32'sd0);
      push_query(32'sh7FFF_0000);
      push_load(2, 32'sh64_0000, 32'sh1234_5678);
      change_count(3);
      push_query(32'sd0);
      push_query(32'sh32_0000);
      push_query(32'sh64_0000);

      for (p = 0; p < 12; p++) begin
         if (p == 4) begin
            wait_drained();
            send_idle_pct = 81;
            recv_idle_pct = 24;
         end else if (p == 8) begin
            wait_drained();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         run_phase(counts[p], 86);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin : watchdog
      #10ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
`default_nettype wire
